// ===== hw/rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types for the signed multiply-divide block.
// ----------------------------------------------------------------------------
package smd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } smd_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } smd_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } smd_stat_t;

endpackage

// ===== hw/rtl/smd_engine.sv =====
// ----------------------------------------------------------------------------
// smd_engine
// Sequenced magnitude datapath: restoring division of |b| by |c|, then
// one shift-and-add step per bit of |a|, sharing one compare-subtract.
// ----------------------------------------------------------------------------
module smd_engine
  import smd_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smd_ctl_t              ctl,
  input  logic [WORD_WIDTH-1:0] mag_a,
  input  logic [WORD_WIDTH-1:0] mag_b,
  input  logic [WORD_WIDTH-1:0] mag_c,
  output smd_stat_t             stat,
  output logic [WORD_WIDTH-1:0] quot_mag,
  output logic [WORD_WIDTH-1:0] rem_mag
);

  localparam int W    = WORD_WIDTH;
  localparam int CW   = $clog2(WORD_WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WORD_WIDTH - 1);

  smd_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  ma_r, ma_nxt;
  logic [W-1:0]  pq_r, pq_nxt;
  logic [W-1:0]  pr_r, pr_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  mc_r;

  logic          div_en, mul_en;

  // shared compare-subtract: {pr, shift-in} against |c|
  logic          shift_in;
  logic [W:0]    sh_val;
  logic [W:0]    sh_diff;
  logic          sh_ge;

  // remainder accumulate
  logic [W-1:0]  rsum;
  logic [W:0]    rsum_diff;
  logic          rsum_ge;

  always_comb begin
    shift_in  = div_en ? pq_r[W-1] : 1'b0;
    sh_val    = {pr_r, shift_in};
    sh_diff   = sh_val - {1'b0, mc_r};
    sh_ge     = ~sh_diff[W];
    rsum      = r_r + pr_r;
    rsum_diff = {1'b0, rsum} - {1'b0, mc_r};
    rsum_ge   = ~rsum_diff[W];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (ctl.start) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_LAST) state_nxt = ST_MUL;
      ST_MUL:  if (ma_r == '0) state_nxt = ST_DONE;
      ST_DONE: if (ctl.ack) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_en    = 1'b0;
    mul_en    = 1'b0;
    stat.idle = 1'b0;
    stat.done = 1'b0;
    unique case (state_r)
      ST_IDLE: stat.idle = 1'b1;
      ST_DIV:  div_en    = 1'b1;
      ST_MUL:  mul_en    = (ma_r != '0);
      ST_DONE: stat.done = 1'b1;
      default: stat.idle = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ma_nxt  = ma_r;
    pq_nxt  = pq_r;
    pr_nxt  = pr_r;
    q_nxt   = q_r;
    r_nxt   = r_r;
    if (stat.idle && ctl.start) begin
      cnt_nxt = '0;
      ma_nxt  = mag_a;
      pq_nxt  = mag_b;
      pr_nxt  = '0;
      q_nxt   = '0;
      r_nxt   = '0;
    end else if (div_en || mul_en) begin
      pq_nxt = {pq_r[W-2:0], sh_ge};
      pr_nxt = sh_ge ? sh_diff[W-1:0] : sh_val[W-1:0];
      if (div_en) begin
        cnt_nxt = cnt_r + CW'(1);
      end
      if (mul_en) begin
        ma_nxt = ma_r >> 1;
        if (ma_r[0]) begin
          q_nxt = q_r + pq_r + W'(rsum_ge);
          r_nxt = rsum_ge ? rsum_diff[W-1:0] : rsum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ma_r  <= ma_nxt;
    pq_r  <= pq_nxt;
    pr_r  <= pr_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    if (stat.idle && ctl.start) begin
      mc_r <= mag_c;
    end
  end

  assign quot_mag = q_r;
  assign rem_mag  = r_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (pr_r < mc_r && r_r < mc_r))
    else $error("partial remainder not below divisor");

  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_LAST) |=> (state_r == ST_MUL))
    else $error("division phase length wrong");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !ctl.ack) |=> (state_r == ST_DONE && $stable(q_r)))
    else $error("result lost before hand-off");

endmodule

// ===== hw/rtl/signed_multiply_divide.sv =====
// ----------------------------------------------------------------------------
// signed_multiply_divide
// Signed a*b/c with a double-width product, giving quotient and remainder.
// ----------------------------------------------------------------------------
// Input channel in_*: one word carries multiplicand, multiplier and divisor.
// Output channel out_*: one word carries quotient and remainder.
// A divisor of zero counts as one; the quotient wraps modulo 2^WORD_WIDTH,
// its sign is the XOR of all three signs, the remainder takes the sign of
// a*b.
// Sequence: load, restoring division of |b| by |c| over all WORD_WIDTH bits,
// then one shift-and-add step per bit of |a| up to its highest set bit, then
// hand-off. The engine works on one word at a time, as the shared
// compare-subtract is reused by every step.
// in_tready is high only while the engine is idle. A finished result moves
// to the output register, so a new word is taken while out_tvalid waits on
// out_tready; the engine holds a second result until the register frees.
// Reset empties the output register and returns the engine to idle.
// ----------------------------------------------------------------------------
module signed_multiply_divide
  import smd_pkg::*;
#(
  parameter int  WORD_WIDTH = 32,
  localparam int IN_W       = ((3 * WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * WORD_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // multiplicand, multiplier, divisor
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // quotient, remainder
);

  localparam int W = WORD_WIDTH;

  logic [W-1:0] a_in, b_in, c_in;
  logic [W-1:0] mag_a, mag_b, mag_c;
  logic         in_acc;
  smd_ctl_t     ctl;
  smd_stat_t    stat;
  logic [W-1:0] quot_mag, rem_mag;

  logic         quot_neg_r, prod_neg_r;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_q_r, out_rem_r;

  assign a_in = in_tdata[W-1:0];
  assign b_in = in_tdata[2*W-1:W];
  assign c_in = in_tdata[3*W-1:2*W];

  always_comb begin
    mag_a = a_in[W-1] ? (W'(0) - a_in) : a_in;
    mag_b = b_in[W-1] ? (W'(0) - b_in) : b_in;
    if (c_in == '0) begin
      mag_c = W'(1);
    end else begin
      mag_c = c_in[W-1] ? (W'(0) - c_in) : c_in;
    end
  end

  assign in_tready = stat.idle;
  assign in_acc    = in_tvalid && in_tready;
  assign ctl.start = in_acc;
  assign ctl.ack   = stat.done && (!out_valid_r || out_tready);

  smd_engine #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .mag_a   (mag_a),
    .mag_b   (mag_b),
    .mag_c   (mag_c),
    .stat    (stat),
    .quot_mag(quot_mag),
    .rem_mag (rem_mag)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_neg_r <= a_in[W-1] ^ b_in[W-1];
      quot_neg_r <= a_in[W-1] ^ b_in[W-1] ^ c_in[W-1];
    end
    if (ctl.ack) begin
      out_q_r   <= quot_neg_r ? (W'(0) - quot_mag) : quot_mag;
      out_rem_r <= prod_neg_r ? (W'(0) - rem_mag) : rem_mag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_rem_r, out_q_r});

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while engine busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output word changed while stalled");

  a_valid_from_ack: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(ctl.ack))
    else $error("output valid without engine hand-off");

endmodule
